// File: hdl/sync_pulse_generator_macros.svh
// Assertion helpers for the sync pulse generator, used by spg_back.
`ifndef SYNC_PULSE_GENERATOR_MACROS_SVH
`define SYNC_PULSE_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPG_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spg assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spg assertion failed");

`endif

// File: hdl/spg_pkg.sv
package spg_pkg;

    localparam int MaxFramesPerTick = 32;
    localparam int FrameCntW = $clog2(MaxFramesPerTick + 1);
    localparam logic [FrameCntW-1:0] MAX_FRAMES_CNT = FrameCntW'(MaxFramesPerTick);

    localparam int DivW = 31;

    // Raw action codes on the input channel.
    localparam logic [2:0] ACT_TICK       = 3'd0;
    localparam logic [2:0] ACT_TRIGGER    = 3'd1;
    localparam logic [2:0] ACT_FRAME      = 3'd2;
    localparam logic [2:0] ACT_START_TEST = 3'd3;
    localparam logic [2:0] ACT_STOP_TEST  = 3'd4;
    localparam logic [2:0] ACT_START_SIM  = 3'd5;
    localparam logic [2:0] ACT_STOP_SIM   = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PULSE_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_TEST_TOTAL     = 3'd1;
    localparam logic [2:0] CFG_TEST_INTERVAL  = 3'd2;
    localparam logic [2:0] CFG_SIM_TOTAL      = 3'd3;
    localparam logic [2:0] CFG_SIM_INTERVAL   = 3'd4;

    localparam logic [19:0] PULSE_WIDTH_RST   = 20'd1000;
    localparam logic [15:0] TEST_TOTAL_RST    = 16'd1;
    localparam logic [30:0] TEST_INTERVAL_RST = 31'd1000000;
    localparam logic [19:0] SIM_TOTAL_RST     = 20'd1;
    localparam logic [30:0] SIM_INTERVAL_RST  = 31'd33333;

    localparam logic [19:0] PULSE_WIDTH_MIN = 20'd10;
    localparam logic [19:0] PULSE_WIDTH_MAX = 20'd1000000;
    localparam logic [20:0] PERIOD_GUARD    = 21'd100;
    localparam logic [30:0] PERIOD_MAX      = 31'd1800000000;
    localparam logic [19:0] SIM_TOTAL_MAX   = 20'd1000000;

    // Result kinds.
    localparam logic [1:0] EV_STATUS     = 2'd0;
    localparam logic [1:0] EV_TEST_PULSE = 2'd1;
    localparam logic [1:0] EV_TEST_END   = 2'd2;
    localparam logic [1:0] EV_FRAME      = 2'd3;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_TRIGGER    = 3'd1,
        OP_FRAME      = 3'd2,
        OP_START_TEST = 3'd3,
        OP_STOP_TEST  = 3'd4,
        OP_START_SIM  = 3'd5,
        OP_STOP_SIM   = 3'd6,
        OP_NOP        = 3'd7
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] now_us;
    } item_t;

    typedef struct packed {
        logic            start;
        logic [DivW-1:0] dividend;
        logic [DivW-1:0] divisor;
    } div_req_t;

endpackage

// File: hdl/sync_pulse_generator.sv
// An accepted transaction is executed in S_EXEC and its results are loaded in S_EMIT; a tick
// passes through S_TEST, S_DIV (the bit-serial remainder unit, only when it fires a test
// pulse) and S_FRAME before S_EMIT. Each transaction ends with a status result flagged last,
// and the next one is taken only after it is loaded; a tick yields at most 32 frame results.
// Results leave at one per cycle while m_ready is high; a two-entry queue buffers input.
// Reset (aresetn low, synchronous) clears control state and restores register defaults.
module sync_pulse_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [31:0] s_now_us,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic        m_sync_level,
    output logic [31:0] m_event_count,
    output logic [30:0] m_lateness_us,
    output logic        m_test_running,
    output logic        m_sim_running,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    logic           q_valid;
    logic           q_pop;
    spg_pkg::item_t q_item;

    assign cfg_ready = 1'b1;

    spg_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .s_now_us (s_now_us),
        .q_pop    (q_pop),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    spg_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_kind   (m_event_kind),
        .m_sync_level   (m_sync_level),
        .m_event_count  (m_event_count),
        .m_lateness_us  (m_lateness_us),
        .m_test_running (m_test_running),
        .m_sim_running  (m_sim_running),
        .m_last         (m_last)
    );

endmodule

// File: hdl/spg_front.sv
module spg_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_action,
    input  logic [31:0]        s_now_us,
    input  logic               q_pop,
    output logic               q_valid,
    output spg_pkg::item_t     q_item
);

    spg_pkg::op_t   op_dec;
    spg_pkg::item_t q_mem [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push;

    always_comb begin
        unique case (s_action)
            spg_pkg::ACT_TICK:       op_dec = spg_pkg::OP_TICK;
            spg_pkg::ACT_TRIGGER:    op_dec = spg_pkg::OP_TRIGGER;
            spg_pkg::ACT_FRAME:      op_dec = spg_pkg::OP_FRAME;
            spg_pkg::ACT_START_TEST: op_dec = spg_pkg::OP_START_TEST;
            spg_pkg::ACT_STOP_TEST:  op_dec = spg_pkg::OP_STOP_TEST;
            spg_pkg::ACT_START_SIM:  op_dec = spg_pkg::OP_START_SIM;
            spg_pkg::ACT_STOP_SIM:   op_dec = spg_pkg::OP_STOP_SIM;
            default:                 op_dec = spg_pkg::OP_NOP;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= '{op: op_dec, now_us: s_now_us};
        end
    end

endmodule

// File: hdl/spg_rem_div.sv
module spg_rem_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  spg_pkg::div_req_t          req,
    output logic                       done,
    output logic [spg_pkg::DivW-1:0]   rem
);

    localparam int CntW = $clog2(spg_pkg::DivW);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CntW-1:0]           cnt_reg, cnt_next;
    logic [spg_pkg::DivW-1:0]  quo_reg, quo_next;
    logic [spg_pkg::DivW-1:0]  rem_reg, rem_next;
    logic [spg_pkg::DivW-1:0]  dvs_reg, dvs_next;
    logic [spg_pkg::DivW:0]    trial;

    // Restoring division, one quotient bit per cycle; only the remainder is kept.
    assign trial = {rem_reg, quo_reg[spg_pkg::DivW-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CntW'(spg_pkg::DivW - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[spg_pkg::DivW-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = spg_pkg::DivW'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[spg_pkg::DivW-1:0];
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: hdl/spg_back.sv
`include "sync_pulse_generator_macros.svh"

module spg_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  spg_pkg::item_t      q_item,
    output logic                q_pop,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [30:0]         cfg_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_event_kind,
    output logic                m_sync_level,
    output logic [31:0]         m_event_count,
    output logic [30:0]         m_lateness_us,
    output logic                m_test_running,
    output logic                m_sim_running,
    output logic                m_last
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_TEST  = 6'b000100,
        S_DIV   = 6'b001000,
        S_FRAME = 6'b010000,
        S_EMIT  = 6'b100000
    } fsm_t;

    localparam int FW = spg_pkg::FrameCntW;

    // Configuration registers.
    logic [19:0] pw_reg, pw_next;
    logic [15:0] ttot_reg, ttot_next;
    logic [30:0] tint_reg, tint_next;
    logic [19:0] stot_reg, stot_next;
    logic [30:0] sint_reg, sint_next;

    // Architectural state.
    logic        line_high_reg, line_high_next;
    logic        pulse_running_reg, pulse_running_next;
    logic [31:0] pulse_start_reg, pulse_start_next;
    logic        test_on_reg, test_on_next;
    logic [15:0] test_done_reg, test_done_next;
    logic [31:0] test_due_reg, test_due_next;
    logic [30:0] test_period_reg, test_period_next;
    logic [15:0] test_total_reg, test_total_next;
    logic [31:0] frame_counter_reg, frame_counter_next;
    logic        sim_on_reg, sim_on_next;
    logic [19:0] sim_done_reg, sim_done_next;
    logic [31:0] sim_due_reg, sim_due_next;
    logic [19:0] sim_total_reg, sim_total_next;
    logic [30:0] sim_period_reg, sim_period_next;

    // Per-transaction sequencing.
    fsm_t          fsm_reg, fsm_next;
    spg_pkg::op_t  op_reg, op_next;
    logic [31:0]   now_reg, now_next;
    logic          ev_test_reg, ev_test_next;
    logic          ev_end_reg, ev_end_next;
    logic [30:0]   late_reg, late_next;
    logic [FW-1:0] nfr_reg, nfr_next;
    logic [FW-1:0] emitted_reg, emitted_next;
    logic [31:0]   frame_base_reg, frame_base_next;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_kind_reg, m_kind_next;
    logic [31:0] m_count_reg, m_count_next;
    logic [30:0] m_late_reg, m_late_next;
    logic        m_last_reg, m_last_next;
    logic        m_sync_reg, m_sync_next;
    logic        m_test_reg, m_test_next;
    logic        m_sim_reg, m_sim_next;

    logic [19:0] width_c;
    logic [20:0] period_lo;
    logic [30:0] period_c;
    logic [19:0] sim_total_c;
    logic [30:0] sim_period_c;
    logic [31:0] test_late;
    logic [31:0] sim_late;
    logic        test_due_now;
    logic        sim_due_now;
    logic        pulse_expired;
    logic [15:0] test_done_inc;
    logic [19:0] sim_done_inc;
    logic        out_load;
    logic        out_last;

    spg_pkg::div_req_t        div_req;
    logic                     div_done;
    logic [spg_pkg::DivW-1:0] div_rem;

    spg_rem_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .rem     (div_rem)
    );

    // Clamped run parameters, evaluated on use.
    always_comb begin
        if (pw_reg < spg_pkg::PULSE_WIDTH_MIN) begin
            width_c = spg_pkg::PULSE_WIDTH_MIN;
        end else if (pw_reg > spg_pkg::PULSE_WIDTH_MAX) begin
            width_c = spg_pkg::PULSE_WIDTH_MAX;
        end else begin
            width_c = pw_reg;
        end
        period_lo = {1'b0, width_c} + spg_pkg::PERIOD_GUARD;
        if (tint_reg < {10'd0, period_lo}) begin
            period_c = {10'd0, period_lo};
        end else if (tint_reg > spg_pkg::PERIOD_MAX) begin
            period_c = spg_pkg::PERIOD_MAX;
        end else begin
            period_c = tint_reg;
        end
        if (stot_reg == 20'd0) begin
            sim_total_c = 20'd1;
        end else if (stot_reg > spg_pkg::SIM_TOTAL_MAX) begin
            sim_total_c = spg_pkg::SIM_TOTAL_MAX;
        end else begin
            sim_total_c = stot_reg;
        end
        if (sint_reg == 31'd0) begin
            sim_period_c = 31'd1;
        end else if (sint_reg > spg_pkg::PERIOD_MAX) begin
            sim_period_c = spg_pkg::PERIOD_MAX;
        end else begin
            sim_period_c = sint_reg;
        end
    end

    // Deadlines are due when the wrapped difference reads as non-negative.
    assign test_late     = now_reg - test_due_reg;
    assign sim_late      = now_reg - sim_due_reg;
    assign test_due_now  = !test_late[31];
    assign sim_due_now   = !sim_late[31];
    assign pulse_expired = pulse_running_reg
                           && ((now_reg - pulse_start_reg) >= {12'd0, width_c});
    assign test_done_inc = test_done_reg + 16'd1;
    assign sim_done_inc  = sim_done_reg + 20'd1;

    assign q_pop    = (fsm_reg == S_IDLE) && q_valid;
    assign out_load = (fsm_reg == S_EMIT) && (!m_valid_reg || m_ready);
    assign out_last = !ev_test_reg && !ev_end_reg && (emitted_reg == nfr_reg);

    always_comb begin
        pw_next   = pw_reg;
        ttot_next = ttot_reg;
        tint_next = tint_reg;
        stot_next = stot_reg;
        sint_next = sint_reg;
        if (cfg_valid) begin
            case (cfg_index)
                spg_pkg::CFG_PULSE_WIDTH:   pw_next   = cfg_data[19:0];
                spg_pkg::CFG_TEST_TOTAL:    ttot_next = cfg_data[15:0];
                spg_pkg::CFG_TEST_INTERVAL: tint_next = cfg_data;
                spg_pkg::CFG_SIM_TOTAL:     stot_next = cfg_data[19:0];
                spg_pkg::CFG_SIM_INTERVAL:  sint_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        line_high_next     = line_high_reg;
        pulse_running_next = pulse_running_reg;
        pulse_start_next   = pulse_start_reg;
        test_on_next       = test_on_reg;
        test_done_next     = test_done_reg;
        test_due_next      = test_due_reg;
        test_period_next   = test_period_reg;
        test_total_next    = test_total_reg;
        frame_counter_next = frame_counter_reg;
        sim_on_next        = sim_on_reg;
        sim_done_next      = sim_done_reg;
        sim_due_next       = sim_due_reg;
        sim_total_next     = sim_total_reg;
        sim_period_next    = sim_period_reg;
        fsm_next           = fsm_reg;
        op_next            = op_reg;
        now_next           = now_reg;
        ev_test_next       = ev_test_reg;
        ev_end_next        = ev_end_reg;
        late_next          = late_reg;
        nfr_next           = nfr_reg;
        emitted_next       = emitted_reg;
        frame_base_next    = frame_base_reg;
        div_req            = '{start: 1'b0, dividend: test_late[30:0],
                               divisor: test_period_reg};
        m_valid_next       = m_valid_reg && !m_ready;
        m_kind_next        = m_kind_reg;
        m_count_next       = m_count_reg;
        m_late_next        = m_late_reg;
        m_last_next        = m_last_reg;
        m_sync_next        = m_sync_reg;
        m_test_next        = m_test_reg;
        m_sim_next         = m_sim_reg;

        unique case (fsm_reg)
            S_IDLE: begin
                if (q_valid) begin
                    op_next      = q_item.op;
                    now_next     = q_item.now_us;
                    ev_test_next = 1'b0;
                    ev_end_next  = 1'b0;
                    nfr_next     = '0;
                    emitted_next = '0;
                    fsm_next     = S_EXEC;
                end
            end
            S_EXEC: begin
                fsm_next = S_EMIT;
                case (op_reg)
                    spg_pkg::OP_TICK: begin
                        if (pulse_expired) begin
                            line_high_next     = 1'b0;
                            pulse_running_next = 1'b0;
                        end
                        fsm_next = S_TEST;
                    end
                    spg_pkg::OP_TRIGGER: begin
                        line_high_next     = 1'b1;
                        pulse_running_next = 1'b1;
                        pulse_start_next   = now_reg;
                    end
                    spg_pkg::OP_FRAME: begin
                        frame_base_next    = frame_counter_reg;
                        frame_counter_next = frame_counter_reg + 32'd1;
                        nfr_next           = FW'(1);
                    end
                    spg_pkg::OP_START_TEST: begin
                        test_total_next  = (ttot_reg == 16'd0) ? 16'd1 : ttot_reg;
                        test_period_next = period_c;
                        test_done_next   = '0;
                        test_due_next    = now_reg;
                        test_on_next     = 1'b1;
                    end
                    spg_pkg::OP_STOP_TEST: begin
                        if (test_on_reg) begin
                            test_on_next = 1'b0;
                            ev_end_next  = 1'b1;
                        end
                    end
                    spg_pkg::OP_START_SIM: begin
                        sim_total_next  = sim_total_c;
                        sim_period_next = sim_period_c;
                        sim_done_next   = '0;
                        sim_due_next    = now_reg;
                        sim_on_next     = 1'b1;
                    end
                    spg_pkg::OP_STOP_SIM: begin
                        sim_on_next = 1'b0;
                    end
                    default: ;
                endcase
            end
            S_TEST: begin
                frame_base_next = frame_counter_reg;
                if (test_on_reg && !pulse_running_reg && test_due_now) begin
                    late_next          = test_late[30:0];
                    test_done_next     = test_done_inc;
                    ev_test_next       = 1'b1;
                    line_high_next     = 1'b1;
                    pulse_running_next = 1'b1;
                    pulse_start_next   = now_reg;
                    if (test_done_inc >= test_total_reg) begin
                        test_on_next = 1'b0;
                        ev_end_next  = 1'b1;
                    end
                    div_req.start = 1'b1;
                    fsm_next      = S_DIV;
                end else begin
                    fsm_next = S_FRAME;
                end
            end
            S_DIV: begin
                // The new deadline is the first whole period strictly past now.
                if (div_done) begin
                    test_due_next = now_reg - {1'b0, div_rem} + {1'b0, test_period_reg};
                    fsm_next      = S_FRAME;
                end
            end
            S_FRAME: begin
                if ((nfr_reg < spg_pkg::MAX_FRAMES_CNT) && sim_on_reg && sim_due_now) begin
                    frame_counter_next = frame_counter_reg + 32'd1;
                    nfr_next           = nfr_reg + FW'(1);
                    sim_done_next      = sim_done_inc;
                    sim_due_next       = sim_due_reg + {1'b0, sim_period_reg};
                    if (sim_done_inc >= sim_total_reg) begin
                        sim_on_next = 1'b0;
                    end
                end else begin
                    fsm_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_sync_next  = line_high_reg;
                    m_test_next  = test_on_reg;
                    m_sim_next   = sim_on_reg;
                    m_late_next  = '0;
                    m_last_next  = 1'b0;
                    if (ev_test_reg) begin
                        m_kind_next  = spg_pkg::EV_TEST_PULSE;
                        m_count_next = {16'd0, test_done_reg};
                        m_late_next  = late_reg;
                        ev_test_next = 1'b0;
                    end else if (ev_end_reg) begin
                        m_kind_next  = spg_pkg::EV_TEST_END;
                        m_count_next = {16'd0, test_done_reg};
                        ev_end_next  = 1'b0;
                    end else if (emitted_reg != nfr_reg) begin
                        m_kind_next  = spg_pkg::EV_FRAME;
                        m_count_next = frame_base_reg + {{(32-FW){1'b0}}, emitted_reg}
                                       + 32'd1;
                        emitted_next = emitted_reg + FW'(1);
                    end else begin
                        m_kind_next  = spg_pkg::EV_STATUS;
                        m_count_next = '0;
                        m_last_next  = 1'b1;
                        fsm_next     = S_IDLE;
                    end
                end
            end
            default: fsm_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_reg            <= spg_pkg::PULSE_WIDTH_RST;
            ttot_reg          <= spg_pkg::TEST_TOTAL_RST;
            tint_reg          <= spg_pkg::TEST_INTERVAL_RST;
            stot_reg          <= spg_pkg::SIM_TOTAL_RST;
            sint_reg          <= spg_pkg::SIM_INTERVAL_RST;
            line_high_reg     <= 1'b0;
            pulse_running_reg <= 1'b0;
            pulse_start_reg   <= '0;
            test_on_reg       <= 1'b0;
            test_done_reg     <= '0;
            test_due_reg      <= '0;
            test_period_reg   <= '0;
            test_total_reg    <= '0;
            frame_counter_reg <= '0;
            sim_on_reg        <= 1'b0;
            sim_done_reg      <= '0;
            sim_due_reg       <= '0;
            sim_total_reg     <= '0;
            sim_period_reg    <= '0;
            fsm_reg           <= S_IDLE;
            ev_test_reg       <= 1'b0;
            ev_end_reg        <= 1'b0;
            nfr_reg           <= '0;
            emitted_reg       <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            pw_reg            <= pw_next;
            ttot_reg          <= ttot_next;
            tint_reg          <= tint_next;
            stot_reg          <= stot_next;
            sint_reg          <= sint_next;
            line_high_reg     <= line_high_next;
            pulse_running_reg <= pulse_running_next;
            pulse_start_reg   <= pulse_start_next;
            test_on_reg       <= test_on_next;
            test_done_reg     <= test_done_next;
            test_due_reg      <= test_due_next;
            test_period_reg   <= test_period_next;
            test_total_reg    <= test_total_next;
            frame_counter_reg <= frame_counter_next;
            sim_on_reg        <= sim_on_next;
            sim_done_reg      <= sim_done_next;
            sim_due_reg       <= sim_due_next;
            sim_total_reg     <= sim_total_next;
            sim_period_reg    <= sim_period_next;
            fsm_reg           <= fsm_next;
            ev_test_reg       <= ev_test_next;
            ev_end_reg        <= ev_end_next;
            nfr_reg           <= nfr_next;
            emitted_reg       <= emitted_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        now_reg        <= now_next;
        late_reg       <= late_next;
        frame_base_reg <= frame_base_next;
        m_kind_reg     <= m_kind_next;
        m_count_reg    <= m_count_next;
        m_late_reg     <= m_late_next;
        m_last_reg     <= m_last_next;
        m_sync_reg     <= m_sync_next;
        m_test_reg     <= m_test_next;
        m_sim_reg      <= m_sim_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_event_kind   = m_kind_reg;
    assign m_sync_level   = m_sync_reg;
    assign m_event_count  = m_count_reg;
    assign m_lateness_us  = m_late_reg;
    assign m_test_running = m_test_reg;
    assign m_sim_running  = m_sim_reg;
    assign m_last         = m_last_reg;

    `SPG_ASSERT_IMPLY(a_div_done_in_div, aclk, aresetn, div_done, fsm_reg == S_DIV)
    `SPG_ASSERT_IMPLY(a_frame_bound, aclk, aresetn, 1'b1, nfr_reg <= spg_pkg::MAX_FRAMES_CNT)
    `SPG_ASSERT_NEXT(a_status_ends_step, aclk, aresetn, out_load && out_last, fsm_reg == S_IDLE)

endmodule

// File: test/tb_top.sv
module tb_top;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [1:0]  kind;
        logic        level;
        logic [31:0] count;
        logic [30:0] late;
        logic        test_run;
        logic        sim_run;
        logic        last;
    } pulse_event_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = spg_pkg::ACT_TICK;
    logic [31:0] s_now_us = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_event_kind;
    logic        m_sync_level;
    logic [31:0] m_event_count;
    logic [30:0] m_lateness_us;
    logic        m_test_running;
    logic        m_sim_running;
    logic        m_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = spg_pkg::CFG_PULSE_WIDTH;
    logic [30:0] cfg_data = '0;

    sync_pulse_generator dut (.*);

    always #4 aclk = ~aclk;

    // Predicts the event stream of the pulse generator and checks it in order.
    class pulse_scoreboard;
        bit [19:0] width_reg;
        bit [15:0] test_total_reg;
        bit [30:0] test_ival_reg;
        bit [19:0] sim_total_reg;
        bit [30:0] sim_ival_reg;

        bit        line_high, pulse_on, test_on, sim_on;
        bit [31:0] pulse_t0, test_due, test_period, frame_no, sim_due;
        bit [31:0] test_total, sim_total, sim_period;
        bit [15:0] test_done;
        bit [19:0] sim_done;

        pulse_event_t pending[$];
        int errors, n_items, n_pulses, n_test_ends, n_frames;

        function new();
            width_reg = spg_pkg::PULSE_WIDTH_RST;
            test_total_reg = spg_pkg::TEST_TOTAL_RST;
            test_ival_reg = spg_pkg::TEST_INTERVAL_RST;
            sim_total_reg = spg_pkg::SIM_TOTAL_RST;
            sim_ival_reg = spg_pkg::SIM_INTERVAL_RST;
            {line_high, pulse_on, test_on, sim_on} = '0;
            {pulse_t0, test_due, test_period, frame_no, sim_due} = '0;
            {test_total, sim_total, sim_period, test_done, sim_done} = '0;
        endfunction

        function bit [31:0] clamp(bit [31:0] v, bit [31:0] lo, bit [31:0] hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function bit is_due(bit [31:0] now, bit [31:0] deadline);
            bit [31:0] d;
            d = now - deadline;
            return !d[31];
        endfunction

        function void push(bit [1:0] kind, bit [31:0] count, bit [30:0] late);
            pulse_event_t e;
            e = '0;
            e.kind = kind;
            e.count = count;
            e.late = late;
            pending.push_back(e);
        endfunction

        function void write_reg(bit [2:0] idx, bit [30:0] data);
            case (idx)
                spg_pkg::CFG_PULSE_WIDTH:   width_reg = data[19:0];
                spg_pkg::CFG_TEST_TOTAL:    test_total_reg = data[15:0];
                spg_pkg::CFG_TEST_INTERVAL: test_ival_reg = data;
                spg_pkg::CFG_SIM_TOTAL:     sim_total_reg = data[19:0];
                spg_pkg::CFG_SIM_INTERVAL:  sim_ival_reg = data;
                default: ;
            endcase
        endfunction

        function void note_input(spg_pkg::op_t op, bit [31:0] now);
            bit [31:0] width, late, periods;
            int first, i;
            first = pending.size();
            width = clamp({12'd0, width_reg}, {12'd0, spg_pkg::PULSE_WIDTH_MIN},
                          {12'd0, spg_pkg::PULSE_WIDTH_MAX});
            n_items++;
            case (op)
                spg_pkg::OP_TICK: begin
                    if (pulse_on && (now - pulse_t0) >= width) begin
                        line_high = 0;
                        pulse_on = 0;
                    end
                    if (test_on && !pulse_on && is_due(now, test_due)) begin
                        late = now - test_due;
                        periods = late / test_period + 32'd1;
                        test_done = test_done + 16'd1;
                        push(spg_pkg::EV_TEST_PULSE, {16'd0, test_done}, late[30:0]);
                        line_high = 1;
                        pulse_on = 1;
                        pulse_t0 = now;
                        test_due = test_due + periods * test_period;
                        if ({16'd0, test_done} >= test_total) begin
                            test_on = 0;
                            push(spg_pkg::EV_TEST_END, {16'd0, test_done}, 31'd0);
                        end
                    end
                    for (i = 0; i < spg_pkg::MaxFramesPerTick && sim_on && is_due(now, sim_due);
                         i++) begin
                        frame_no++;
                        push(spg_pkg::EV_FRAME, frame_no, 31'd0);
                        sim_done = sim_done + 20'd1;
                        sim_due = sim_due + sim_period;
                        if ({12'd0, sim_done} >= sim_total) sim_on = 0;
                    end
                end
                spg_pkg::OP_TRIGGER: begin
                    line_high = 1;
                    pulse_on = 1;
                    pulse_t0 = now;
                end
                spg_pkg::OP_FRAME: begin
                    frame_no++;
                    push(spg_pkg::EV_FRAME, frame_no, 31'd0);
                end
                spg_pkg::OP_START_TEST: begin
                    test_total = (test_total_reg == 16'd0) ? 32'd1 : {16'd0, test_total_reg};
                    test_period = clamp({1'b0, test_ival_reg},
                                        width + {11'd0, spg_pkg::PERIOD_GUARD},
                                        {1'b0, spg_pkg::PERIOD_MAX});
                    test_done = 0;
                    test_due = now;
                    test_on = 1;
                end
                spg_pkg::OP_STOP_TEST: begin
                    if (test_on) begin
                        test_on = 0;
                        push(spg_pkg::EV_TEST_END, {16'd0, test_done}, 31'd0);
                    end
                end
                spg_pkg::OP_START_SIM: begin
                    sim_total = clamp({12'd0, sim_total_reg}, 32'd1,
                                      {12'd0, spg_pkg::SIM_TOTAL_MAX});
                    sim_period = clamp({1'b0, sim_ival_reg}, 32'd1, {1'b0, spg_pkg::PERIOD_MAX});
                    sim_done = 0;
                    sim_due = now;
                    sim_on = 1;
                end
                spg_pkg::OP_STOP_SIM: sim_on = 0;
                default: ;
            endcase
            push(spg_pkg::EV_STATUS, 32'd0, 31'd0);
            pending[pending.size() - 1].last = 1;
            // Level and mode flags reflect the state after the whole transaction.
            for (i = first; i < pending.size(); i++) begin
                pending[i].level = line_high;
                pending[i].test_run = test_on;
                pending[i].sim_run = sim_on;
                case (pending[i].kind)
                    spg_pkg::EV_TEST_PULSE: n_pulses++;
                    spg_pkg::EV_TEST_END:   n_test_ends++;
                    spg_pkg::EV_FRAME:      n_frames++;
                    default: ;
                endcase
            end
        endfunction

        function void field(string name, bit [31:0] e, bit [31:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
            end
        endfunction

        function void check_result(pulse_event_t got);
            pulse_event_t e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, actual %p", $time, got);
                return;
            end
            e = pending.pop_front();
            field("event_kind", 32'(e.kind), 32'(got.kind));
            field("sync_level", 32'(e.level), 32'(got.level));
            field("event_count", e.count, got.count);
            field("lateness_us", 32'(e.late), 32'(got.late));
            field("test_running", 32'(e.test_run), 32'(got.test_run));
            field("sim_running", 32'(e.sim_run), 32'(got.sim_run));
            field("last", 32'(e.last), 32'(got.last));
        endfunction
    endclass

    pulse_scoreboard sb = new();

    bit        steady = 0;
    bit        hold_req = 0;
    bit        hold_done = 0;
    int        hold_cnt = 0;
    int        quiet_cycles = 0;
    bit [31:0] t_now = '0;

    // Result side: random back-pressure plus one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_cnt > 0) begin
            m_ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_done) begin
            m_ready <= 1'b0;
            hold_cnt <= 400;
            hold_done <= 1'b1;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_event_kind, m_sync_level, m_event_count, m_lateness_us,
                              m_test_running, m_sim_running, m_last});
        if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready)
                || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(spg_pkg::op_t op, bit [31:0] now);
        s_valid <= 1'b1;
        s_action <= op;
        s_now_us <= now;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(op, now);
        if (!steady && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic set_regs(int unsigned w, int unsigned tt, int unsigned ti, int unsigned st,
                            int unsigned si);
        bit [30:0] vals[5];
        vals = '{31'(w), 31'(tt), 31'(ti), 31'(st), 31'(si)};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(i[2:0], vals[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic spg_pkg::op_t pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return spg_pkg::OP_TICK;
        if (r < 65) return spg_pkg::OP_TRIGGER;
        if (r < 70) return spg_pkg::OP_FRAME;
        if (r < 77) return spg_pkg::OP_START_TEST;
        if (r < 81) return spg_pkg::OP_STOP_TEST;
        if (r < 88) return spg_pkg::OP_START_SIM;
        if (r < 92) return spg_pkg::OP_STOP_SIM;
        if (r < 95) return spg_pkg::OP_NOP;
        return spg_pkg::op_t'($urandom_range(0, 7));
    endfunction

    // Time mostly moves forward in small steps; a few transactions, or all in wide mode, jump anywhere.
    task automatic run_random(int n, int step_max, bit wide);
        for (int k = 0; k < n; k++) begin
            if (wide || $urandom_range(0, 99) < 4)
                t_now = $urandom;
            else
                t_now = t_now + $urandom_range(0, step_max);
            send(pick_op(), t_now);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part with the default register values.
        send(spg_pkg::OP_TICK, 32'd0);
        send(spg_pkg::OP_NOP, 32'hFFFF_FFFF);
        send(spg_pkg::OP_STOP_TEST, 32'd5);
        send(spg_pkg::OP_TRIGGER, 32'hFFFF_FC00);
        send(spg_pkg::OP_TICK, 32'h0000_0100);
        send(spg_pkg::OP_FRAME, 32'h0000_0180);
        send(spg_pkg::OP_START_TEST, 32'h0000_0200);
        send(spg_pkg::OP_TICK, 32'h0000_0300);
        send(spg_pkg::OP_START_TEST, 32'd1000);
        send(spg_pkg::OP_START_TEST, 32'd1500);
        send(spg_pkg::OP_TICK, 32'd1500);
        send(spg_pkg::OP_TRIGGER, 32'd2000);
        send(spg_pkg::OP_TICK, 32'd2600);
        send(spg_pkg::OP_TICK, 32'd3100);
        send(spg_pkg::OP_START_SIM, 32'd3100);
        send(spg_pkg::OP_TICK, 32'd3100);
        send(spg_pkg::OP_START_SIM, 32'd4000);
        send(spg_pkg::OP_START_TEST, 32'd4000);
        send(spg_pkg::OP_STOP_TEST, 32'd4100);
        send(spg_pkg::OP_STOP_SIM, 32'd4200);
        send(spg_pkg::OP_TICK, 32'h7FFF_FFFF);
        send(spg_pkg::OP_TICK, 32'h8000_0000);
        t_now = 32'h8000_0000;
        drain();

        // Zero everywhere: every register clamps up.
        set_regs(0, 0, 0, 0, 0);
        send(spg_pkg::OP_START_SIM, t_now);
        t_now = t_now + 32'd500;
        send(spg_pkg::OP_TICK, t_now);
        run_random(50, 200, 0);
        drain();

        // Moderate settings with a long hold-off on the result side.
        set_regs($urandom_range(10, 400), $urandom_range(2, 20), $urandom_range(50, 1500),
                 $urandom_range(5, 60), $urandom_range(1, 300));
        hold_req = 1;
        run_random(80, 300, 0);
        drain();

        // Largest field values.
        set_regs(32'hFFFFF, 32'hFFFF, 32'h7FFF_FFFF, 32'hFFFFF, 32'h7FFF_FFFF);
        run_random(30, 0, 1);
        drain();

        // Upper limits within range, then a stretch without idling.
        set_regs(1000000, 65535, 1800000000, 1000000, 1800000000);
        run_random(10, 0, 1);
        drain();
        set_regs($urandom_range(10, 200), $urandom_range(1, 8), $urandom_range(1, 600),
                 $urandom_range(1, 40), $urandom_range(1, 100));
        steady = 1;
        run_random(40, 150, 0);
        steady = 0;
        run_random(30, 150, 0);
        drain();

        $display("Covered %0d transactions: %0d test pulses, %0d test ends, %0d frame results.",
                 sb.n_items, sb.n_pulses, sb.n_test_ends, sb.n_frames);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("simulation failed");
        end
        $finish;
    end
endmodule
